@@ sv/ita_pkg.sv @@
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; used by ita_front, ita_back and integer_to_ascii_formatter.
package ita_pkg;

	// Field widths
	localparam int KIND_W     = 3;
	localparam int VALUE_W    = 64;
	localparam int DEC_W      = 32;
	localparam int CHAR_W     = 7;
	localparam int COUNT_W    = 5;
	localparam int NIB_W      = 4;
	localparam int DEC_DIGITS = 10;
	localparam int HEX_DIGITS = 16;
	localparam int BCD_W      = DEC_DIGITS * NIB_W;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
	// Letter bases shifted down by ten so a digit value 10..15 adds straight on
	localparam logic [CHAR_W-1:0] CH_UPPER_BASE = 7'h37;
	localparam logic [CHAR_W-1:0] CH_LOWER_BASE = 7'h57;

	// Input format codes
	typedef enum logic [KIND_W-1:0] {
		KIND_SDEC = 3'd0,
		KIND_UDEC = 3'd1,
		KIND_HEXU = 3'd2,
		KIND_HEXL = 3'd3,
		KIND_PTR  = 3'd4
	} kind_t;

	// Work mode handed from front to back
	typedef enum logic [1:0] {
		MODE_DEC  = 2'd0,
		MODE_HEXU = 2'd1,
		MODE_HEXL = 2'd2,
		MODE_PTR  = 2'd3
	} mode_t;

	// One classified command in the queue
	typedef struct packed {
		mode_t              mode;
		logic               neg;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	// One hex or BCD digit to its ASCII character
	function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [NIB_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-NIB_W){1'b0}}, d};
		if (d < 4'd10) begin
			return CH_ZERO + dx;
		end else if (upper) begin
			return CH_UPPER_BASE + dx;
		end else begin
			return CH_LOWER_BASE + dx;
		end
	endfunction

endpackage

@@ sv/ita_front.sv @@
// Front end of the formatter: accepts input transactions, classifies the kind,
// takes the decimal magnitude, and queues commands. Depends on ita_pkg.
module ita_front import ita_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [KIND_W-1:0]  kind,
	input  logic [VALUE_W-1:0] value,
	output cmd_t               q_cmd,
	output logic               q_valid,
	input  logic               q_pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic              in_ok;
	logic              neg;
	logic [DEC_W-1:0]  low;
	logic [DEC_W-1:0]  mag;
	cmd_t              cmd_in;
	logic              wr;
	logic              rd;

	cmd_t              queue_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	// Classify: decimal kinds keep the low word, negative signed takes its magnitude
	assign low = value[DEC_W-1:0];

	always_comb begin
		in_ok       = 1'b1;
		neg         = 1'b0;
		cmd_in.mode = MODE_DEC;
		unique case (kind) inside
			KIND_SDEC: begin
				neg = low[DEC_W-1];
			end
			KIND_UDEC: begin
				neg = 1'b0;
			end
			KIND_HEXU: cmd_in.mode = MODE_HEXU;
			KIND_HEXL: cmd_in.mode = MODE_HEXL;
			KIND_PTR:  cmd_in.mode = MODE_PTR;
			default:   in_ok = 1'b0;
		endcase
		mag = neg ? (DEC_W'(0) - low) : low;
		cmd_in.neg = neg;
		if (cmd_in.mode == MODE_DEC) begin
			cmd_in.value = {{(VALUE_W-DEC_W){1'b0}}, mag};
		end else begin
			cmd_in.value = value;
		end
	end

	// Queue control; unused kinds are taken and dropped
	assign full    = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign wr      = push && !full && in_ok;
	assign rd      = q_pop && q_valid;
	assign q_cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !q_pop) |=> (cnt_q == $past(cnt_q)))
		else $error("queue count moved while full and not popped");

	a_drop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !in_ok && !q_pop) |=> $stable(cnt_q))
		else $error("unused kind entered the queue");

endmodule

@@ sv/ita_back.sv @@
// Back end of the formatter: converts queued commands to digits, trims leading
// zeros and emits characters through an output register. Depends on ita_pkg.
module ita_back import ita_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               q_cmd,
	input  logic               q_valid,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic [CHAR_W-1:0]  character,
	output logic               last,
	output logic [COUNT_W-1:0] char_count
);

	localparam int ITER_W = $clog2(DEC_W);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CONV   = 5'b00010,
		ST_TRIM   = 5'b00100,
		ST_PREFIX = 5'b01000,
		ST_DIGITS = 5'b10000
	} state_t;

	state_t              state_q;
	mode_t               mode_q;
	logic                neg_q;
	logic [VALUE_W-1:0]  digs_q;
	logic [DEC_W-1:0]    bin_q;
	logic [ITER_W-1:0]   iter_q;
	logic [COUNT_W-1:0]  ndig_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [COUNT_W-1:0]  total_q;
	logic                pidx_q;

	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic [COUNT_W-1:0]  count_q;

	logic [BCD_W-1:0]    bcd_adj;
	logic [BCD_W-1:0]    bcd_next;
	logic [1:0]          npre;
	logic [NIB_W-1:0]    top_nib;
	logic                slot_free;
	logic                emit;
	logic [CHAR_W-1:0]   emit_char;
	logic                emit_last;
	logic                prefix_end;

	// Double-dabble step: add three to every BCD digit of five or more
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			logic [NIB_W-1:0] d;
			d = digs_q[VALUE_W-BCD_W + i*NIB_W +: NIB_W];
			bcd_adj[i*NIB_W +: NIB_W] = (d >= 4'd5) ? d + 4'd3 : d;
		end
		bcd_next = {bcd_adj[BCD_W-2:0], bin_q[DEC_W-1]};
	end

	// Prefix length: minus sign, "0x", or none
	always_comb begin
		if (neg_q) begin
			npre = 2'd1;
		end else if (mode_q == MODE_PTR) begin
			npre = 2'd2;
		end else begin
			npre = 2'd0;
		end
	end

	assign top_nib    = digs_q[VALUE_W-1 -: NIB_W];
	assign slot_free  = !out_valid_q || pop;
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign emit       = slot_free && ((state_q == ST_PREFIX) || (state_q == ST_DIGITS));
	assign prefix_end = neg_q || pidx_q;

	// Character chosen for this cycle
	always_comb begin
		if (state_q == ST_PREFIX) begin
			emit_char = neg_q ? CH_MINUS : (pidx_q ? CH_X : CH_ZERO);
			emit_last = 1'b0;
		end else begin
			emit_char = nibble_ascii(top_nib, mode_q == MODE_HEXU);
			emit_last = (rem_q == COUNT_W'(1));
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			pidx_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						iter_q  <= '0;
						pidx_q  <= 1'b0;
						state_q <= (q_cmd.mode == MODE_DEC) ? ST_CONV : ST_TRIM;
					end
				end
				ST_CONV: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(DEC_W - 1)) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (!((top_nib == '0) && (ndig_q != COUNT_W'(1)))) begin
						state_q <= (npre != 2'd0) ? ST_PREFIX : ST_DIGITS;
					end
				end
				ST_PREFIX: begin
					if (emit) begin
						pidx_q <= 1'b1;
						if (prefix_end) begin
							state_q <= ST_DIGITS;
						end
					end
				end
				ST_DIGITS: begin
					if (emit && emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Digit datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					mode_q <= q_cmd.mode;
					neg_q  <= q_cmd.neg;
					bin_q  <= q_cmd.value[DEC_W-1:0];
					if (q_cmd.mode == MODE_DEC) begin
						digs_q <= '0;
						ndig_q <= COUNT_W'(DEC_DIGITS);
					end else begin
						digs_q <= q_cmd.value;
						ndig_q <= COUNT_W'(HEX_DIGITS);
					end
				end
			end
			ST_CONV: begin
				digs_q <= {bcd_next, {(VALUE_W-BCD_W){1'b0}}};
				bin_q  <= {bin_q[DEC_W-2:0], 1'b0};
			end
			ST_TRIM: begin
				if ((top_nib == '0) && (ndig_q != COUNT_W'(1))) begin
					digs_q <= {digs_q[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
					ndig_q <= ndig_q - 1'b1;
				end else begin
					rem_q   <= ndig_q;
					total_q <= ndig_q + {{(COUNT_W-2){1'b0}}, npre};
				end
			end
			ST_PREFIX: begin
			end
			ST_DIGITS: begin
				if (emit) begin
					digs_q <= {digs_q[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
					rem_q  <= rem_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q  <= emit_char;
			last_q  <= emit_last;
			count_q <= emit_last ? total_q : '0;
		end
	end

	assign empty      = !out_valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign char_count = count_q;

	// Checks
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (rem_q != '0))
		else $error("digit phase with nothing left to emit");

	a_ndig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM) |-> ((ndig_q != '0) && (ndig_q <= COUNT_W'(HEX_DIGITS))))
		else $error("digit count out of range");

	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> ((count_q != '0) && (count_q <= COUNT_W'(18))))
		else $error("final character with bad count");

	a_count_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (count_q == '0))
		else $error("non-final character with nonzero count");

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// Top level of the integer-to-ASCII formatter: front end, command queue, back end.
// Depends on ita_pkg, ita_front and ita_back.
//
//   channel  direction  handshake           payload
//   input    in         push / full         kind[2:0], value[63:0]
//   result   out        empty / pop         character[6:0], last, char_count[4:0]
//
// Each number is loaded, then for the decimal kinds converted by shift-and-add-3,
// then trimmed of its leading zero digits (up to 9 decimal or 15 hex), then
// emitted character by character (up to 18 characters). The back end's digit
// register works on one number at a time. The front queue holds DEPTH commands
// so input keeps flowing while the back end converts.
// Reset is asynchronous and empties the queue and output register; pop held low
// stalls the back end at its next character without losing anything.
module integer_to_ascii_formatter import ita_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [KIND_W-1:0]  kind,
	input  logic [VALUE_W-1:0] value,
	output logic               empty,
	input  logic               pop,
	output logic [CHAR_W-1:0]  character,
	output logic               last,
	output logic [COUNT_W-1:0] char_count
);

	cmd_t q_cmd;
	logic q_valid;
	logic q_pop;

	// Accept, classify and queue
	ita_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.kind   (kind),
		.value  (value),
		.q_cmd  (q_cmd),
		.q_valid(q_valid),
		.q_pop  (q_pop)
	);

	// Convert and emit characters
	ita_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (q_cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last),
		.char_count(char_count)
	);

endmodule

@@ tb/tb.sv @@
// Testbench for integer_to_ascii_formatter: directed numbers, then random bursts.
// Every character popped is checked against expected text, typed in by hand or from a predictor kept here.
// Depends on ita_pkg and integer_to_ascii_formatter.
module tb;
	import ita_pkg::*;

	// Kind codes the block ignores
	localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD_MID = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

	// Letters for hex digits ten and up
	localparam logic [CHAR_W-1:0] LETTER_UP = 7'h41;
	localparam logic [CHAR_W-1:0] LETTER_LOW = 7'h61;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_NUMBERS = 225;
	localparam int HOLD_AFTER_GLYPHS = 400;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT = 400000;

	// One character on the result side
	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic               fin;
		logic [COUNT_W-1:0] count;
	} glyph_t;

	// One directed number; empty text means the predictor supplies the result
	typedef struct {
		logic [KIND_W-1:0]  k;
		logic [VALUE_W-1:0] v;
		string              text;
	} plan_row_t;

	typedef enum {POP_DRAIN, POP_CHOPPY, POP_TRICKLE} pop_style_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [KIND_W-1:0]  kind = '0;
	logic [VALUE_W-1:0] value = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [CHAR_W-1:0]  character;
	logic               last;
	logic [COUNT_W-1:0] char_count;

	glyph_t pending_glyphs [$];
	int     errors = 0;
	int     glyphs_seen = 0;
	int     cycles = 0;

	plan_row_t directed_plan [DIRECTED_ROWS] = '{
		'{KIND_SDEC, 64'd0, "0"},
		'{KIND_SDEC, 64'd1, "1"},
		'{KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, "-1"},
		'{KIND_SDEC, 64'h0000_0000_8000_0000, "-2147483648"},
		'{KIND_SDEC, 64'h0000_0000_7FFF_FFFF, "2147483647"},
		'{KIND_SDEC, 64'hDEAD_BEEF_0000_007B, "123"},
		'{KIND_SDEC, 64'h0000_0000_FFFF_FF85, "-123"},
		'{KIND_UDEC, 64'd0, "0"},
		'{KIND_UDEC, 64'h0000_0000_FFFF_FFFF, "4294967295"},
		'{KIND_UDEC, 64'h0000_0000_8000_0000, "2147483648"},
		'{KIND_UDEC, 64'hFFFF_FFFF_0000_0000, "0"},
		'{KIND_UDEC, 64'd1000000000, ""},
		'{KIND_HEXU, 64'd0, "0"},
		'{KIND_HEXU, 64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"},
		'{KIND_HEXU, 64'h0123_4567_89AB_CDEF, "123456789ABCDEF"},
		'{KIND_HEXU, 64'h8000_0000_0000_0000, "8000000000000000"},
		'{KIND_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"},
		'{KIND_HEXL, 64'hFEDC_BA98_7654_3210, "fedcba9876543210"},
		'{KIND_HEXL, 64'hA, "a"},
		'{KIND_PTR, 64'd0, "0x0"},
		'{KIND_PTR, 64'hFFFF_FFFF_FFFF_FFFF, "0xffffffffffffffff"},
		'{KIND_PTR, 64'h0000_7FFF_FFFF_F000, ""},
		'{KIND_RSVD_LO, 64'd0, ""},
		'{KIND_RSVD_MID, 64'h5A5A_A5A5_1234_8765, ""},
		'{KIND_RSVD_HI, 64'hFFFF_FFFF_FFFF_FFFF, ""}
	};

	integer_to_ascii_formatter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.character  (character),
		.last       (last),
		.char_count (char_count)
	);

	// Clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Append characters in print order, marking the final one with the count
	function automatic void queue_glyphs(input logic [CHAR_W-1:0] text [$]);
		glyph_t g;
		for (int i = 0; i < text.size(); i++) begin
			g.ch = text[i];
			g.fin = (i == text.size() - 1);
			g.count = g.fin ? COUNT_W'(text.size()) : '0;
			pending_glyphs.push_back(g);
		end
	endfunction

	// Expected text for a directed row typed in by hand
	function automatic void queue_typed(input string s);
		logic [CHAR_W-1:0] text [$];
		for (int i = 0; i < s.len(); i++) begin
			text.push_back(CHAR_W'(s[i]));
		end
		queue_glyphs(text);
	endfunction

	// Predict the text the block prints for one number
	function automatic void spell_number(input logic [KIND_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		logic [CHAR_W-1:0] text [$];
		logic [CHAR_W-1:0] digits [$];
		logic [DEC_W-1:0]  mag;
		logic [DEC_W-1:0]  rem;
		logic [VALUE_W-1:0] rest;
		logic [NIB_W-1:0]  nib;
		logic              upper;
		case (k)
			KIND_SDEC, KIND_UDEC: begin
				mag = v[DEC_W-1:0];
				if (k == KIND_SDEC && mag[DEC_W-1]) begin
					text.push_back(CH_MINUS);
					mag = '0 - mag;
				end
				do begin
					rem = mag % 10;
					digits.push_front(CH_ZERO + rem[CHAR_W-1:0]);
					mag = mag / 10;
				end while (mag != 0);
			end
			KIND_HEXU, KIND_HEXL, KIND_PTR: begin
				if (k == KIND_PTR) begin
					text.push_back(CH_ZERO);
					text.push_back(CH_X);
				end
				upper = (k == KIND_HEXU);
				rest = v;
				do begin
					nib = rest[NIB_W-1:0];
					if (nib < 10)
						digits.push_front(CH_ZERO + CHAR_W'(nib));
					else
						digits.push_front((upper ? LETTER_UP : LETTER_LOW) + CHAR_W'(nib) - 7'd10);
					rest = rest >> NIB_W;
				end while (rest != 0);
			end
			default: return;
		endcase
		foreach (digits[i]) text.push_back(digits[i]);
		queue_glyphs(text);
	endfunction

	// Offer one number and hold it until the block takes it
	task automatic offer_number(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
			input string typed);
		@(negedge clk);
		push = 1'b1;
		kind = k;
		value = v;
		do @(posedge clk); while (full);
		if (typed.len() != 0)
			queue_typed(typed);
		else
			spell_number(k, v);
	endtask

	// Drop push for a while, with junk on the payload
	task automatic idle_input(input int n);
		@(negedge clk);
		push = 1'b0;
		kind = KIND_W'($urandom);
		value = {$urandom, $urandom};
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		idle_input(0);
		while (pending_glyphs.size() != 0) @(posedge clk);
	endtask

	// Random number shaped to hit short, long and boundary outputs
	function automatic logic [VALUE_W-1:0] pick_value();
		int               roll;
		logic [31:0]      small_mag;
		logic [VALUE_W-1:0] full_word;
		roll = $urandom_range(99, 0);
		full_word = {$urandom, $urandom};
		small_mag = $urandom_range(20, 0);
		if (roll < 35)
			return full_word;
		else if (roll < 60)
			return full_word >> $urandom_range(63, 0);
		else if (roll < 72)
			return {$urandom, small_mag};
		else if (roll < 86)
			return {$urandom, 32'd0 - small_mag};
		else
			return (64'd1 << $urandom_range(63, 0)) - $urandom_range(1, 0);
	endfunction

	// Sender: directed table, then random bursts
	initial begin
		int numbers_sent;
		int burst;
		int gap;
		bit drained_once;
		logic [KIND_W-1:0] k;
		numbers_sent = 0;
		drained_once = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_number(directed_plan[i].k, directed_plan[i].v, directed_plan[i].text);
			if ($urandom_range(3, 0) == 0) idle_input($urandom_range(6, 1));
		end
		wait_drained();

		while (numbers_sent < RANDOM_NUMBERS) begin
			burst = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 15) : $urandom_range(8, 1);
			gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(15, 1);
			repeat (burst) begin
				if ($urandom_range(99, 0) < 8)
					k = KIND_W'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
				else
					k = KIND_W'($urandom_range(KIND_PTR, KIND_SDEC));
				offer_number(k, pick_value(), "");
				if (k <= KIND_PTR) numbers_sent++;
			end
			if (!drained_once && numbers_sent >= RANDOM_NUMBERS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end else if (gap != 0) begin
				idle_input(gap);
			end
		end

		// Wait out the last results, then watch for strays
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: stalls in stretches of varying style, one long hold-off
	initial begin
		int run_len;
		pop_style_t style;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = $urandom_range(40, 1);
			style = pop_style_t'($urandom_range(2, 0));
			repeat (run_len) begin
				@(negedge clk);
				case (style)
					POP_DRAIN:   pop = 1'b1;
					POP_CHOPPY:  pop = $urandom_range(1, 0);
					POP_TRICKLE: pop = ($urandom_range(7, 0) == 0);
				endcase
			end
			// Hold off long enough to fill the block and stall the sender
			if (!held && glyphs_seen >= HOLD_AFTER_GLYPHS) begin
				@(negedge clk);
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
		end
	end

	// Check each popped character against the oldest expectation
	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && pop && !empty) begin
			glyphs_seen++;
			if (pending_glyphs.size() == 0) begin
				$display("%0t: unexpected character %h last %b count %0d", $time,
					character, last, char_count);
				errors++;
			end else begin
				want = pending_glyphs.pop_front();
				if (character !== want.ch) begin
					$display("%0t: character expected %h got %h", $time, want.ch, character);
					errors++;
				end
				if (last !== want.fin) begin
					$display("%0t: last expected %b got %b", $time, want.fin, last);
					errors++;
				end
				if (char_count !== want.count) begin
					$display("%0t: char_count expected %0d got %0d", $time, want.count,
						char_count);
					errors++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d characters outstanding", $time,
				pending_glyphs.size());
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
